### sv/qfi_token_bucket_policer_top_assert.svh
// Assertion macros for the QFI policer top level.
`ifndef QFI_TOKEN_BUCKET_POLICER_TOP_ASSERT_SVH
`define QFI_TOKEN_BUCKET_POLICER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define QTBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while in reset.
`define QTBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/qtbp_pkg.sv
`default_nettype none

package qtbp_pkg;

    // Timestamp width
    localparam int TIME_BITS   = 48;
    localparam int ELAP_HI_W   = TIME_BITS - 32;
    localparam int E1R_W       = ELAP_HI_W + 32;
    localparam int PHI_W       = E1R_W + 1;

    // Packet classification
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  QFI_MASK       = 8'h3F;
    localparam int          QFI_W          = 6;

    // Refill scaling: divide by 1000000 = 2^6 * 15625
    localparam logic [19:0] US_PER_S  = 20'd1000000;
    localparam int          DIV_SHIFT = 6;
    localparam int          Y_W       = 46;
    localparam int          Y_HI_W    = Y_W - 32;
    localparam int          RECIP_W   = 47;
    localparam int          RECIP_HI_W = RECIP_W - 32;
    // ceil(2^60 / 15625), exact quotient for any 46-bit dividend
    localparam logic [RECIP_W-1:0] RECIP = 47'd73786976294839;
    localparam int          RECIP_SHIFT_HI = 60 - 32;
    localparam int          T_W       = 49;
    localparam int          Q_SUM_W   = 34;

    // Pipeline depth ahead of the result register
    localparam int PIPE_STAGES = 7;

    // APB register map
    localparam int ADDR_W = 4;
    typedef enum logic [1:0] {
        REG_POLICE_ENABLE = 2'd0,
        REG_POLICED_QFI   = 2'd1,
        REG_RATE          = 2'd2,
        REG_BUCKET_SIZE   = 2'd3
    } reg_idx_t;

endpackage

`default_nettype wire

### sv/qfi_token_bucket_policer_top.sv
`default_nettype none

// QFI token bucket policer. Each input transaction carries one packet descriptor
// (ethertype, IP protocol, TOS byte, length, microsecond timestamp) and yields one
// result transaction (verdict: 0 pass, 1 drop; was_policed: the packet was metered).
// Only IPv4 TCP packets whose QFI (TOS low six bits) equals policed_qfi are metered,
// and only while police_enable is set; all others pass untouched. A metered packet
// first refills the single bucket by floor(elapsed_us * rate / 1000000), capped at
// bucket_size, then takes packet_len tokens if they are there, else it is dropped.
// Time running backwards adds nothing; the refill timestamp always moves to the
// packet's timestamp. Throughput is one transaction per clock unless m_ready
// stalls the output; each transaction passes through an input register that classifies
// the packet, six refill stages (elapsed time, 48x32 rate product in two partial
// products, fold of the upper half, divide by 1000000 via a shift and a reciprocal
// multiply in four partial products, sum of the partial products, quotient), then
// the bucket update into the result register. Back-pressure on m_ready fills the
// pipeline before s_ready falls. Registers (APB, byte address 4*i): 0 police_enable,
// 1 policed_qfi, 2 rate_bytes_per_s, 3 bucket_size. Configure only while no
// transaction is in flight.
// No clearing pass after reset: the bucket and timestamp start at zero.

`include "qfi_token_bucket_policer_top_assert.svh"

module qfi_token_bucket_policer_top
    import qtbp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [15:0]          s_ether_type,
    input  wire logic [7:0]           s_ip_proto,
    input  wire logic [7:0]           s_tos_byte,
    input  wire logic [15:0]          s_packet_len,
    input  wire logic [TIME_BITS-1:0] s_now_us,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_verdict,
    output logic                      m_was_policed,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic              police_enable_reg;
    logic [QFI_W-1:0]  policed_qfi_reg;
    logic [31:0]       rate_reg;
    logic [31:0]       bucket_size_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_POLICE_ENABLE: prdata = {31'd0, police_enable_reg};
            REG_POLICED_QFI:   prdata = {{(32-QFI_W){1'b0}}, policed_qfi_reg};
            REG_RATE:          prdata = rate_reg;
            REG_BUCKET_SIZE:   prdata = bucket_size_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage takes new data when it is empty or
    // when the stage after it is taking its contents.
    // ------------------------------------------------------------------
    logic [PIPE_STAGES-1:0] stg_v_reg;
    logic [PIPE_STAGES:0]   stg_rdy;
    logic [PIPE_STAGES-1:0] stg_in_v;
    logic [PIPE_STAGES-1:0] stg_ld;
    logic                   m_valid_reg;
    logic                   res_load;

    always_comb begin
        stg_rdy[PIPE_STAGES] = !m_valid_reg || m_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            stg_rdy[k] = !stg_v_reg[k] || stg_rdy[k+1];
        end
    end

    assign stg_in_v = {stg_v_reg[PIPE_STAGES-2:0], s_valid};
    assign stg_ld   = stg_rdy[PIPE_STAGES-1:0] & stg_in_v;
    assign res_load = stg_rdy[PIPE_STAGES] && stg_v_reg[PIPE_STAGES-1];
    assign s_ready  = stg_rdy[0];

    // ------------------------------------------------------------------
    // Stage 0: classify at acceptance and snapshot the refill timestamp.
    // The refill timestamp only depends on earlier metered packets, so it
    // is tracked here, at the head of the pipe.
    // ------------------------------------------------------------------
    logic                 match_in;
    logic [TIME_BITS-1:0] last_now_reg;
    logic [TIME_BITS-1:0] now0_reg;
    logic [TIME_BITS-1:0] prev0_reg;

    assign match_in = (s_ether_type == ETHERTYPE_IPV4) && (s_ip_proto == PROTO_TCP) &&
                      police_enable_reg &&
                      ((s_tos_byte & QFI_MASK) == {{(8-QFI_W){1'b0}}, policed_qfi_reg});

    // Match flag and length travel with every stage
    logic [PIPE_STAGES-1:0] match_reg;
    logic [15:0]            len_reg [PIPE_STAGES];

    // ------------------------------------------------------------------
    // Stage 1: elapsed time, zero when time ran backwards
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0] elap1_next;
    logic [TIME_BITS-1:0] elap1_reg;

    assign elap1_next = (now0_reg >= prev0_reg) ? (now0_reg - prev0_reg) : '0;

    // ------------------------------------------------------------------
    // Stage 2: elapsed * rate as two partial products
    // ------------------------------------------------------------------
    logic [63:0]      e0r2_next;
    logic [E1R_W-1:0] e1r2_next;
    logic [63:0]      e0r2_reg;
    logic [E1R_W-1:0] e1r2_reg;

    assign e0r2_next = 64'(elap1_reg[31:0]) * 64'(rate_reg);
    assign e1r2_next = E1R_W'(elap1_reg[TIME_BITS-1:32]) * E1R_W'(rate_reg);

    // ------------------------------------------------------------------
    // Stage 3: fold the upper half of the product
    // ------------------------------------------------------------------
    logic [PHI_W-1:0] phi3_next;
    logic [PHI_W-1:0] phi3_reg;
    logic [31:0]      plo3_reg;

    assign phi3_next = PHI_W'(e1r2_reg) + PHI_W'(e0r2_reg[63:32]);

    // ------------------------------------------------------------------
    // Stage 4: saturation test, drop the factor 2^6, then multiply by the
    // reciprocal of 15625 in four partial products. A product at or above
    // 1000000 * 2^32 gives a refill past any bucket, so it saturates.
    // ------------------------------------------------------------------
    logic                  sat4_next;
    logic [Y_W-1:0]        y4;
    logic [63:0]           pp00_next;
    logic [RECIP_HI_W+31:0] pp01_next;
    logic [Y_HI_W+31:0]    pp10_next;
    logic [Y_HI_W+RECIP_HI_W-1:0] pp11_next;
    logic                  sat4_reg;
    logic [63:0]           pp00_reg;
    logic [RECIP_HI_W+31:0] pp01_reg;
    logic [Y_HI_W+31:0]    pp10_reg;
    logic [Y_HI_W+RECIP_HI_W-1:0] pp11_reg;

    assign sat4_next = phi3_reg >= PHI_W'(US_PER_S);
    assign y4        = {phi3_reg[Y_W-(32-DIV_SHIFT)-1:0], plo3_reg[31:DIV_SHIFT]};
    assign pp00_next = 64'(y4[31:0]) * 64'(RECIP[31:0]);
    assign pp01_next = (RECIP_HI_W+32)'(y4[31:0]) * (RECIP_HI_W+32)'(RECIP[RECIP_W-1:32]);
    assign pp10_next = (Y_HI_W+32)'(y4[Y_W-1:32]) * (Y_HI_W+32)'(RECIP[31:0]);
    assign pp11_next = (Y_HI_W+RECIP_HI_W)'(y4[Y_W-1:32]) *
                       (Y_HI_W+RECIP_HI_W)'(RECIP[RECIP_W-1:32]);

    // ------------------------------------------------------------------
    // Stage 5: sum the middle partial products; the low 32 bits of the
    // lowest product cannot reach bit 60, only its carry word matters
    // ------------------------------------------------------------------
    logic [T_W-1:0]        t5_next;
    logic [T_W-1:0]        t5_reg;
    logic                  sat5_reg;
    logic [Y_HI_W+RECIP_HI_W-1:0] pp11_5_reg;

    assign t5_next = T_W'(pp01_reg) + T_W'(pp10_reg) + T_W'(pp00_reg[63:32]);

    // ------------------------------------------------------------------
    // Stage 6: quotient = product >> 60
    // ------------------------------------------------------------------
    logic [Q_SUM_W-1:0] q6_sum;
    logic [31:0]        q6_reg;
    logic               sat6_reg;

    assign q6_sum = Q_SUM_W'({pp11_5_reg, 4'd0}) + Q_SUM_W'(t5_reg[T_W-1:RECIP_SHIFT_HI]);

    // ------------------------------------------------------------------
    // Result stage: refill, cap, test and consume tokens
    // ------------------------------------------------------------------
    logic [31:0] token_count_reg;
    logic [32:0] tok_sum;
    logic [31:0] tok_cap;
    logic        tok_pass;
    logic [31:0] token_count_next;
    logic        verdict_reg;
    logic        policed_reg;
    logic        match_last;
    logic [15:0] len_last;

    assign match_last = match_reg[PIPE_STAGES-1];
    assign len_last   = len_reg[PIPE_STAGES-1];

    always_comb begin
        tok_sum = 33'(token_count_reg) + 33'(q6_reg);
        if (sat6_reg || (tok_sum > 33'(bucket_size_reg))) begin
            tok_cap = bucket_size_reg;
        end else begin
            tok_cap = tok_sum[31:0];
        end
        tok_pass = tok_cap >= 32'(len_last);
        // Drop leaves the refilled, capped tokens in place
        token_count_next = tok_pass ? (tok_cap - 32'(len_last)) : tok_cap;
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            police_enable_reg <= 1'b0;
            policed_qfi_reg   <= '0;
            rate_reg          <= '0;
            bucket_size_reg   <= '0;
            stg_v_reg         <= '0;
            m_valid_reg       <= 1'b0;
            last_now_reg      <= '0;
            token_count_reg   <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_POLICE_ENABLE: police_enable_reg <= pwdata[0];
                    REG_POLICED_QFI:   policed_qfi_reg   <= pwdata[QFI_W-1:0];
                    REG_RATE:          rate_reg          <= pwdata;
                    REG_BUCKET_SIZE:   bucket_size_reg   <= pwdata;
                endcase
            end
            for (int k = 0; k < PIPE_STAGES; k++) begin
                if (stg_rdy[k]) begin
                    stg_v_reg[k] <= stg_in_v[k];
                end
            end
            if (stg_rdy[PIPE_STAGES]) begin
                m_valid_reg <= stg_v_reg[PIPE_STAGES-1];
            end
            // Advance the refill timestamp as each metered packet enters
            if (stg_ld[0] && match_in) begin
                last_now_reg <= s_now_us;
            end
            if (res_load && match_last) begin
                token_count_reg <= token_count_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers, qualified by the valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (stg_ld[0]) begin
            match_reg[0] <= match_in;
            len_reg[0]   <= s_packet_len;
            now0_reg     <= s_now_us;
            prev0_reg    <= last_now_reg;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (stg_ld[k]) begin
                match_reg[k] <= match_reg[k-1];
                len_reg[k]   <= len_reg[k-1];
            end
        end
        if (stg_ld[1]) begin
            elap1_reg <= elap1_next;
        end
        if (stg_ld[2]) begin
            e0r2_reg <= e0r2_next;
            e1r2_reg <= e1r2_next;
        end
        if (stg_ld[3]) begin
            phi3_reg <= phi3_next;
            plo3_reg <= e0r2_reg[31:0];
        end
        if (stg_ld[4]) begin
            sat4_reg <= sat4_next;
            pp00_reg <= pp00_next;
            pp01_reg <= pp01_next;
            pp10_reg <= pp10_next;
            pp11_reg <= pp11_next;
        end
        if (stg_ld[5]) begin
            t5_reg     <= t5_next;
            sat5_reg   <= sat4_reg;
            pp11_5_reg <= pp11_reg;
        end
        if (stg_ld[6]) begin
            q6_reg   <= q6_sum[31:0];
            sat6_reg <= sat5_reg;
        end
        if (res_load) begin
            verdict_reg <= match_last && !tok_pass;
            policed_reg <= match_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_verdict     = verdict_reg;
    assign m_was_policed = policed_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Only a metered packet can be dropped
    `QTBP_ASSERT_NOW(a_drop_only_policed, m_valid && !m_was_policed, !m_verdict, "unmetered packet dropped")
    // Metering never leaves more tokens than the bucket holds
    `QTBP_ASSERT_NEXT(a_tokens_capped, res_load && match_last, token_count_reg <= $past(bucket_size_reg), "tokens above bucket size")
    // Unmatched packets leave the bucket alone
    `QTBP_ASSERT_NEXT(a_unmatched_keeps, res_load && !match_last, $stable(token_count_reg), "bucket changed by unmatched packet")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import qtbp_pkg::*;

    // Generous ceiling on the length of the slowest legal run.
    localparam int          CYCLE_LIMIT  = 200_000;
    // Extra wait after the last result, for any stray result to show up.
    localparam int          DRAIN_CYCLES = 16;
    localparam logic [19:0] USEC_PER_SEC = 20'd1_000_000;

    // One packet descriptor as presented on the input channel.
    typedef struct {
        logic [15:0]          ether_type;
        logic [7:0]           ip_proto;
        logic [7:0]           tos_byte;
        logic [15:0]          packet_len;
        logic [TIME_BITS-1:0] now_us;
    } pkt_desc_t;

    // Decision for one packet as returned on the result channel.
    typedef struct {
        logic verdict;
        logic was_policed;
    } pkt_outcome_t;

    // Every input of the block starts at a known value.
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [15:0]          s_ether_type  = '0;
    logic [7:0]           s_ip_proto    = '0;
    logic [7:0]           s_tos_byte    = '0;
    logic [15:0]          s_packet_len  = '0;
    logic [TIME_BITS-1:0] s_now_us      = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic                 m_verdict;
    logic                 m_was_policed;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [ADDR_W-1:0]    paddr         = '0;
    logic [31:0]          pwdata        = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Shadow copy of the policy registers and the bucket state.
    logic                 pol_enable    = 1'b0;
    logic [5:0]           pol_qfi       = '0;
    logic [31:0]          pol_rate      = '0;
    logic [31:0]          pol_depth     = '0;
    logic [31:0]          bucket_tokens = '0;
    logic [TIME_BITS-1:0] last_refill   = '0;

    // Outcomes of accepted packets, oldest first.
    pkt_outcome_t         outcome_q[$];

    // Free-running packet clock used by the random traffic.
    logic [TIME_BITS-1:0] wall_us       = '0;

    int errors          = 0;
    int n_packets       = 0;
    int n_metered       = 0;
    int n_dropped       = 0;
    int n_policies      = 0;
    int src_gap_odds    = 0;   // 0: no gaps, else one chance in this many per transaction
    int sink_stall_odds = 0;   // 0: no stalls, else one chance in this many per cycle
    int sink_stall_left = 0;
    int cycle_count     = 0;

    qfi_token_bucket_policer_top dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bucket predictor: classify, refill exactly, cap, then meter.
    // ------------------------------------------------------------------
    function automatic pkt_outcome_t meter_packet(pkt_desc_t p);
        logic [TIME_BITS-1:0] elapsed;
        logic [TIME_BITS+32:0] level;
        pkt_outcome_t o;
        o.verdict     = 1'b0;
        o.was_policed = p.ether_type == ETHERTYPE_IPV4 && p.ip_proto == PROTO_TCP &&
                        pol_enable && (p.tos_byte & QFI_MASK) == {2'b00, pol_qfi};
        if (o.was_policed) begin
            // Time running backwards adds nothing.
            elapsed = (p.now_us >= last_refill) ? p.now_us - last_refill : '0;
            // Full-width product, so no wrap; the fraction of a token is lost.
            level = (elapsed * pol_rate) / USEC_PER_SEC;
            level = level + bucket_tokens;
            if (level > pol_depth)
                level = pol_depth;
            last_refill = p.now_us;
            if (level >= p.packet_len)
                level = level - p.packet_len;
            else
                o.verdict = 1'b1;
            bucket_tokens = level[31:0];
        end
        return o;
    endfunction

    function automatic pkt_desc_t make_pkt(logic [15:0] ether_type, logic [7:0] ip_proto,
                                           logic [7:0] tos_byte, logic [15:0] packet_len,
                                           logic [TIME_BITS-1:0] now_us);
        pkt_desc_t p;
        p.ether_type = ether_type;
        p.ip_proto   = ip_proto;
        p.tos_byte   = tos_byte;
        p.packet_len = packet_len;
        p.now_us     = now_us;
        return p;
    endfunction

    // Mostly well-formed IPv4 TCP packets on the policed QFI with random ECN bits;
    // the rest is noise on the classifier fields.
    function automatic pkt_desc_t random_packet();
        pkt_desc_t p;
        // Advance the clock in small steps; now and then stand still, step back,
        // or jump anywhere in the timestamp range.
        case ($urandom_range(0, 39))
            0, 1: ;
            2, 3: if (wall_us > 1000) wall_us = wall_us - TIME_BITS'($urandom_range(1, 1000));
            4:    wall_us = TIME_BITS'({$urandom, $urandom});
            default: wall_us = wall_us + TIME_BITS'($urandom_range(1, 400));
        endcase
        p.now_us     = wall_us;
        p.ether_type = ETHERTYPE_IPV4;
        p.ip_proto   = PROTO_TCP;
        p.tos_byte   = {2'($urandom_range(0, 3)), pol_qfi};
        case ($urandom_range(0, 19))
            0: p.ether_type = 16'($urandom);
            1: p.ip_proto   = 8'($urandom);
            2: p.tos_byte   = 8'($urandom);
            3: begin
                p.ether_type = 16'($urandom);
                p.ip_proto   = 8'($urandom);
                p.tos_byte   = 8'($urandom);
            end
            default: ;
        endcase
        case ($urandom_range(0, 19))
            0:       p.packet_len = '0;
            1, 2:    p.packet_len = 16'($urandom);
            default: p.packet_len = 16'($urandom_range(40, 1500));
        endcase
        return p;
    endfunction

    function automatic int pick_odds();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
    endfunction

    // ------------------------------------------------------------------
    // Input channel: present one descriptor, hold it until accepted.
    // ------------------------------------------------------------------
    task automatic send_packet(input pkt_desc_t p);
        pkt_outcome_t o;
        if (src_gap_odds != 0 && $urandom_range(1, src_gap_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_ether_type <= p.ether_type;
        s_ip_proto   <= p.ip_proto;
        s_tos_byte   <= p.tos_byte;
        s_packet_len <= p.packet_len;
        s_now_us     <= p.now_us;
        do @(posedge aclk); while (!s_ready);
        // Predict at acceptance, in order of acceptance.
        o = meter_packet(p);
        outcome_q.push_back(o);
        n_packets++;
        if (o.was_policed) n_metered++;
        if (o.verdict)     n_dropped++;
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic settle_results();
        s_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port. Consecutive writes chain setup straight after access;
    // release the bus once a batch is done.
    // ------------------------------------------------------------------
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_POLICE_ENABLE: pol_enable = value[0];
            REG_POLICED_QFI:   pol_qfi    = value[5:0];
            REG_RATE:          pol_rate   = value;
            REG_BUCKET_SIZE:   pol_depth  = value;
            default: ;
        endcase
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Install a whole policy once the pipeline is empty. Unused upper bits of
    // the narrow registers carry junk, which the block must ignore.
    task automatic set_policy(input logic enable, input logic [5:0] qfi,
                              input logic [31:0] rate, input logic [31:0] depth);
        settle_results();
        write_reg(REG_POLICE_ENABLE, {31'($urandom), enable});
        write_reg(REG_POLICED_QFI, {26'($urandom), qfi});
        write_reg(REG_RATE, rate);
        write_reg(REG_BUCKET_SIZE, depth);
        apb_release();
        n_policies++;
    endtask

    // ------------------------------------------------------------------
    // Result channel: stalls in random bursts.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (sink_stall_left != 0) begin
            m_ready <= 1'b0;
            sink_stall_left = sink_stall_left - 1;
        end else if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1) begin
            m_ready <= 1'b0;
            sink_stall_left = $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each returned decision against the oldest outstanding prediction.
    always @(posedge aclk) begin : check_results
        pkt_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: result with no packet outstanding: verdict %0b was_policed %0b",
                         $time, m_verdict, m_was_policed);
                errors++;
            end else begin
                want = outcome_q.pop_front();
                if (m_verdict !== want.verdict) begin
                    $display("%0t: verdict mismatch: expected %0b, got %0b",
                             $time, want.verdict, m_verdict);
                    errors++;
                end
                if (m_was_policed !== want.was_policed) begin
                    $display("%0t: was_policed mismatch: expected %0b, got %0b",
                             $time, want.was_policed, m_was_policed);
                    errors++;
                end
            end
        end
    end

    // Watchdog: abandon a run that has stopped making progress.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, outcome_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves policing off; then exercise the classifier, where only
    // IPv4 TCP on the policed QFI is metered.
    task automatic test_unmatched_traffic();
        src_gap_odds    = 4;
        sink_stall_odds = 4;
        // Policing disabled: even a packet on QFI 0 passes unmetered.
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h00, 16'd100, 48'd5));
        set_policy(1'b1, 6'd10, 32'd1_000_000, 32'd3000);
        send_packet(make_pkt(16'h86DD, PROTO_TCP, 8'h0A, 16'd100, 48'd10));
        send_packet(make_pkt(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 48'd20));
        send_packet(make_pkt(16'h0000, 8'h00, 8'h00, 16'h0000, 48'd30));
        send_packet(make_pkt(ETHERTYPE_IPV4, 8'd17, 8'h0A, 16'd100, 48'd40));
        // Neighbouring QFI must not match.
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h0B, 16'd100, 48'd50));
        // ECN bits set on the policed QFI: metered, 1000 us refill covers 500 bytes.
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'hCA, 16'd500, 48'd1000));
    endtask

    // Exact fit, one byte short, zero length, time going backwards, refill
    // capped at the bucket and the refill fraction being lost.
    task automatic test_metering_basics();
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h0A, 16'd501, 48'd1000));
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h0A, 16'd500, 48'd1000));
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h0A, 16'd0, 48'd1000));
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h4A, 16'd1, 48'd900));
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h8A, 16'd3000, 48'd4900));
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h0A, 16'hFFFF, 48'd4900));
        // 1.5 bytes per microsecond: each step yields one whole token only.
        set_policy(1'b1, 6'd10, 32'd1_500_000, 32'd3000);
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h0A, 16'd1, 48'd4901));
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h0A, 16'd2, 48'd4902));
    endtask

    // Widest product, bucket shrunk below the held tokens, zero rate and
    // zero depth, highest QFI.
    task automatic test_bucket_limits();
        set_policy(1'b1, 6'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h0A, 16'hFFFF, 48'hFFFF_FFFF_FFFF));
        // Shrink the bucket while it holds nearly 2^32 tokens.
        settle_results();
        write_reg(REG_BUCKET_SIZE, 32'd100);
        apb_release();
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h0A, 16'd101, 48'hFFFF_FFFF_FFFF));
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h0A, 16'd100, 48'hFFFF_FFFF_FFFF));
        set_policy(1'b1, 6'd63, 32'd0, 32'd0);
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h3F, 16'd0, 48'hFFFF_FFFF_FFFF));
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'hFF, 16'd1, 48'hFFFF_FFFF_FFFF));
        send_packet(make_pkt(ETHERTYPE_IPV4, PROTO_TCP, 8'h3F, 16'd0, 48'd0));
    endtask

    // Random traffic under a series of policies, with random idling on both
    // sides and a full drain half way through each phase.
    task automatic test_random_policies();
        wall_us = 48'd5000;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_policy(1'b0, 6'($urandom), $urandom_range(100_000, 20_000_000), 32'd20000);
                1: set_policy(1'b1, 6'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: set_policy(1'b1, 6'd0, 32'd0, 32'($urandom_range(0, 3000)));
                3: set_policy(1'b1, 6'd63, $urandom, $urandom_range(0, 65535));
                default: set_policy(1'b1, 6'($urandom), $urandom_range(100_000, 20_000_000),
                                    $urandom_range(1500, 20000));
            endcase
            src_gap_odds    = pick_odds();
            sink_stall_odds = pick_odds();
            for (int i = 0; i < 250; i++) begin
                // Hold off the sender until the pipeline has fully drained.
                if (i == 125) settle_results();
                send_packet(random_packet());
            end
        end
    endtask

    // Closing stretch at full rate: no gaps, no stalls.
    task automatic test_back_to_back();
        set_policy(1'b1, 6'($urandom), $urandom_range(1_000_000, 10_000_000),
                   $urandom_range(1500, 20000));
        src_gap_odds    = 0;
        sink_stall_odds = 0;
        for (int i = 0; i < 300; i++)
            send_packet(random_packet());
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_unmatched_traffic();
        test_metering_basics();
        test_bucket_limits();
        test_random_policies();
        test_back_to_back();

        // Drain, then leave room for any stray result to show up.
        settle_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d packet descriptors under %0d policy settings", n_packets, n_policies);
        $display("%0d were metered against the bucket, %0d of those dropped", n_metered, n_dropped);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
